// File: rtl/core/sha1h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types and constants for the streaming SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1h_pkg;

  // Channel payloads
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Round constants
  localparam logic [31:0] K_R0 = 32'h5A82_7999;
  localparam logic [31:0] K_R1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K_R3 = 32'hCA62_C1D6;

  // Initial chaining value, entry 0 is word H0
  localparam logic [4:0][31:0] INIT_VECTOR = {
    32'hC3D2_E1F0, 32'h1032_5476, 32'h98BA_DCFE, 32'hEFCD_AB89, 32'h6745_2301
  };

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;  // first byte of the length field
  localparam logic [5:0] FILL_LAST = 6'd63;  // last byte of a block

  localparam logic [6:0] ROUND_P1   = 7'd20;
  localparam logic [6:0] ROUND_P2   = 7'd40;
  localparam logic [6:0] ROUND_P3   = 7'd60;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  localparam logic [2:0] LAST_WORD_IDX = 3'd4;

  // Source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    SRC_MSG  = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  // Round function group
  typedef enum logic [1:0] {
    PH_CHOOSE = 2'd0,
    PH_PARITY = 2'd1,
    PH_MAJOR  = 2'd2,
    PH_PAR_HI = 2'd3
  } phase_t;

  // Controller to datapath
  typedef struct packed {
    logic      shift_en;   // shift one byte into the buffer
    byte_src_t src;
    logic      cnt_inc;    // message byte counted
    logic      load_wv;    // working variables from chaining value
    logic      round_en;
    phase_t    phase;
    logic      add_chain;
    logic      restart;    // back to initial vector, count cleared
    logic [2:0] word_sel;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_last;
    logic fill_len;
  } dp_stat_t;

endpackage

// File: rtl/core/sha1h_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha1h_in_if;
  logic                 valid;
  logic                 ready;
  sha1h_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sha1h_out_if;
  logic                 valid;
  logic                 ready;
  sha1h_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/sha1h_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_dp
// Block buffer / schedule shift line, round unit, chaining value and counts.
// ----------------------------------------------------------------------------
module sha1h_dp import sha1h_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [7:0] in_byte,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_item
);

  // Bytes enter at the low end; the oldest schedule word sits at the top.
  logic [511:0]      blk_r;
  logic [5:0]        fill_r;
  logic [60:0]       cnt_r;
  logic [4:0][31:0]  chain_r;
  logic [31:0]       a_r, b_r, c_r, d_r, e_r;

  logic [63:0] len;
  logic [7:0]  len_byte;
  logic [7:0]  byte_sel;
  logic [31:0] w0, w2, w8, w13, w_mix, w_new;
  logic [31:0] f, k, tmp;

  assign len      = {cnt_r, 3'b000};
  assign len_byte = 8'(len >> {~fill_r[2:0], 3'b000});

  always_comb begin
    case (cmd.src)
      SRC_MSG:  byte_sel = in_byte;
      SRC_PAD:  byte_sel = PAD_BYTE;
      SRC_ZERO: byte_sel = 8'h00;
      SRC_LEN:  byte_sel = len_byte;
      default:  byte_sel = 8'h00;
    endcase
  end

  // Window holds W[t..t+15]; next word is W[t+16]
  assign w0    = blk_r[511:480];
  assign w2    = blk_r[447:416];
  assign w8    = blk_r[255:224];
  assign w13   = blk_r[95:64];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    case (cmd.phase)
      PH_CHOOSE: begin
        f = (b_r & c_r) | (~b_r & d_r);
        k = K_R0;
      end
      PH_PARITY: begin
        f = b_r ^ c_r ^ d_r;
        k = K_R1;
      end
      PH_MAJOR: begin
        f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k = K_R2;
      end
      default: begin
        f = b_r ^ c_r ^ d_r;
        k = K_R3;
      end
    endcase
  end

  assign tmp = {a_r[26:0], a_r[31:27]} + f + e_r + k + w0;

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk_r <= {blk_r[503:0], byte_sel};
    end else if (cmd.round_en) begin
      blk_r <= {blk_r[479:0], w_new};
    end

    if (cmd.load_wv) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round_en) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      cnt_r   <= '0;
      chain_r <= INIT_VECTOR;
    end else begin
      if (cmd.shift_en) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.restart) begin
        cnt_r   <= '0;
        chain_r <= INIT_VECTOR;
      end else begin
        if (cmd.cnt_inc) begin
          cnt_r <= cnt_r + 61'd1;
        end
        if (cmd.add_chain) begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          chain_r[4] <= chain_r[4] + e_r;
        end
      end
    end
  end

  assign stat.fill_last = (fill_r == FILL_LAST);
  assign stat.fill_len  = (fill_r == LEN_POS);

  always_comb begin
    case (cmd.word_sel)
      3'd0:    out_item.digest_word = chain_r[0];
      3'd1:    out_item.digest_word = chain_r[1];
      3'd2:    out_item.digest_word = chain_r[2];
      3'd3:    out_item.digest_word = chain_r[3];
      default: out_item.digest_word = chain_r[4];
    endcase
  end
  assign out_item.word_index = cmd.word_sel;
  assign out_item.last_word  = (cmd.word_sel == LAST_WORD_IDX);

endmodule

// File: rtl/core/sha1h_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_ctrl
// Sequencer: byte intake, padding, round count and digest readout.
// ----------------------------------------------------------------------------
module sha1h_ctrl import sha1h_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_byte_valid,
  input  logic     in_is_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PAD80  = 3'd1;
  localparam logic [2:0] ST_PADZ   = 3'd2;
  localparam logic [2:0] ST_PADLEN = 3'd3;
  localparam logic [2:0] ST_ROUND  = 3'd4;
  localparam logic [2:0] ST_FOLD   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r, ret_nxt;      // where to go after the chaining update
  logic [6:0] round_r, round_nxt;
  logic [2:0] word_r, word_nxt;

  always_comb begin
    cmd       = '0;
    cmd.src   = SRC_MSG;
    cmd.phase = PH_CHOOSE;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    round_nxt = round_r;
    word_nxt  = word_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte_valid) begin
            cmd.shift_en = 1'b1;
            cmd.cnt_inc  = 1'b1;
          end
          if (in_byte_valid && stat.fill_last) begin
            cmd.load_wv = 1'b1;
            round_nxt   = '0;
            state_nxt   = ST_ROUND;
            ret_nxt     = in_is_last ? ST_PAD80 : ST_IDLE;
          end else if (in_is_last) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        cmd.shift_en = 1'b1;
        cmd.src      = SRC_PAD;
        if (stat.fill_last) begin
          cmd.load_wv = 1'b1;
          round_nxt   = '0;
          state_nxt   = ST_ROUND;
          ret_nxt     = ST_PADZ;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (stat.fill_len) begin
          state_nxt = ST_PADLEN;
        end else begin
          cmd.shift_en = 1'b1;
          cmd.src      = SRC_ZERO;
          // no room for the length: finish this block, pad a fresh one
          if (stat.fill_last) begin
            cmd.load_wv = 1'b1;
            round_nxt   = '0;
            state_nxt   = ST_ROUND;
            ret_nxt     = ST_PADZ;
          end
        end
      end
      ST_PADLEN: begin
        cmd.shift_en = 1'b1;
        cmd.src      = SRC_LEN;
        if (stat.fill_last) begin
          cmd.load_wv = 1'b1;
          round_nxt   = '0;
          state_nxt   = ST_ROUND;
          ret_nxt     = ST_OUT;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (round_r < ROUND_P1) begin
          cmd.phase = PH_CHOOSE;
        end else if (round_r < ROUND_P2) begin
          cmd.phase = PH_PARITY;
        end else if (round_r < ROUND_P3) begin
          cmd.phase = PH_MAJOR;
        end else begin
          cmd.phase = PH_PAR_HI;
        end
        round_nxt = round_r + 7'd1;
        if (round_r == ROUND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.add_chain = 1'b1;
        word_nxt      = '0;
        state_nxt     = ret_r;
      end
      ST_OUT: begin
        out_valid    = 1'b1;
        cmd.word_sel = word_r;
        if (out_ready) begin
          if (word_r == LAST_WORD_IDX) begin
            cmd.restart = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            word_nxt = word_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      round_r <= '0;
      word_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      round_r <= round_nxt;
      word_r  <= word_nxt;
    end
  end

endmodule

// File: rtl/core/sha1_message_hasher.sv
`timescale 1ns / 1ps
// Intake: one byte per cycle while idle; each full 64-byte block then holds
//   intake through 80 rounds of the single round unit and the fold.
// End of message: padding, then one or two block compressions, then five
//   digest words, one per accepted output transaction.
// Reset (synchronous, active low) restores the initial vector and clears counts.
// ----------------------------------------------------------------------------
// sha1_message_hasher
// Streaming SHA-1: byte intake, padding, compression and digest readout.
// ----------------------------------------------------------------------------
module sha1_message_hasher import sha1h_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  sha1h_in_if.sink           in_ch,
  sha1h_out_if.source        out_ch
);

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t out_item;

  sha1h_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_byte_valid (in_ch.data.byte_valid),
    .in_is_last    (in_ch.data.is_last),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  sha1h_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_ch.data.msg_byte),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

  assign out_ch.data = out_item;

endmodule

// File: rtl/core/sha1h_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_checker
// Port-level checks on the hasher's channels, bound to the top level.
// ----------------------------------------------------------------------------
module sha1h_checker import sha1h_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // Intake and readout never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest words are pending");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == LAST_WORD_IDX)))
    else $error("last_word does not match word_index");

  // Words come out in order with no gap
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && (out_word_index == $past(out_word_index) + 3'd1)))
    else $error("digest word sequence broken");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (!out_valid && in_ready))
    else $error("no return to intake after the final digest word");

  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_word_index == 3'd0))
    else $error("digest does not start at word 0");

endmodule

bind sha1_message_hasher sha1h_checker u_sha1h_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_word_index (out_ch.data.word_index),
  .out_last_word  (out_ch.data.last_word)
);
